// ===== design/hrle_pkg.sv =====
// Package for the colour to LED serial-code encoder.
// Holds payload and configuration types, register indexes, sizing constants
// and the hue region helpers. Depends on nothing.
`default_nettype none

package hrle_pkg;

    localparam int COLOR_W      = 24;
    localparam int CODE_W       = 7;
    localparam int CFG_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CNT_W        = 5;
    localparam int QUEUE_DEPTH  = 2;

    // Beat number of the gap beat; the bit beats come before it.
    localparam logic [CNT_W-1:0] LAST_BEAT = 5'd24;
    localparam logic [CNT_W-1:0] TOP_BIT   = 5'd23;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_BYTES = 2'd2;

    localparam logic [7:0] HIGH_CODE_RST = 8'd248;
    localparam logic [7:0] LOW_CODE_RST  = 8'd192;
    localparam logic [7:0] GAP_BYTES_RST = 8'd100;

    localparam logic [7:0] FULL_SCALE  = 8'd255;
    localparam logic [7:0] REGION_SPAN = 8'd43;

    typedef enum logic [2:0] {
        RGN_0,
        RGN_1,
        RGN_2,
        RGN_3,
        RGN_4,
        RGN_5
    } hue_region_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] chan_a;
        logic [7:0] chan_b;
        logic [7:0] chan_c;
    } in_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_byte;
        logic [7:0]        gap_len;
        logic              last;
    } out_t;

    typedef struct packed {
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
    } grb_t;

    typedef struct packed {
        logic [CFG_W-1:0] high_code;
        logic [CFG_W-1:0] low_code;
        logic [CFG_W-1:0] gap_bytes;
    } cfg_t;

    // Six hue regions of 43 steps each, the last one shorter; hues 215 and up all land in it.
    function automatic hue_region_t region_of(input logic [7:0] hue);
        hue_region_t rgn;
        if (hue < 8'd43) begin
            rgn = RGN_0;
        end else if (hue < 8'd86) begin
            rgn = RGN_1;
        end else if (hue < 8'd129) begin
            rgn = RGN_2;
        end else if (hue < 8'd172) begin
            rgn = RGN_3;
        end else if (hue < 8'd215) begin
            rgn = RGN_4;
        end else begin
            rgn = RGN_5;
        end
        return rgn;
    endfunction

    function automatic logic [7:0] region_base(input hue_region_t rgn);
        logic [7:0] base;
        case (rgn)
            RGN_0:   base = 8'd0;
            RGN_1:   base = REGION_SPAN;
            RGN_2:   base = 8'd86;
            RGN_3:   base = 8'd129;
            RGN_4:   base = 8'd172;
            RGN_5:   base = 8'd215;
            default: base = 8'd0;
        endcase
        return base;
    endfunction

endpackage

`default_nettype wire

// ===== design/hrle_front.sv =====
// Front end: accepts colour beats and turns HSV into RGB in three stages.
// Produces one GRB word per item toward the queue. Depends on hrle_pkg.
`default_nettype none

module hrle_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  hrle_pkg::in_t        in_data,
    output logic                 word_valid,
    input  wire                  word_ready,
    output hrle_pkg::grb_t       word_data
);
    import hrle_pkg::*;

    // Stage 1: region, remainder, grey flag.
    logic        v1_reg;
    logic        kind1_reg, zero1_reg;
    logic [7:0]  a1_reg, b1_reg, c1_reg, rem1_reg;
    hue_region_t rgn1_reg;

    // Stage 2: first products.
    logic        v2_reg;
    logic        kind2_reg, zero2_reg;
    logic [7:0]  a2_reg, b2_reg, c2_reg;
    hue_region_t rgn2_reg;
    logic [15:0] pprod2_reg, qs2_reg, ts2_reg;

    // Stage 3: finished colour word.
    logic        v3_reg;
    grb_t        word3_reg;

    logic        adv1, adv2, adv3;
    hue_region_t rgn_in;
    logic [7:0]  diff_in;
    logic [10:0] rem_wide;
    logic [15:0] qprod, tprod;
    logic [7:0]  p_val, q_val, t_val;
    grb_t        word_next;

    assign adv3     = !v3_reg || word_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign rgn_in   = region_of(in_data.chan_a);
    assign diff_in  = in_data.chan_a - region_base(rgn_in);
    assign rem_wide = 11'(diff_in) * 11'd6;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= in_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
            if (adv3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            kind1_reg <= in_data.kind;
            zero1_reg <= (in_data.chan_b == 8'd0);
            a1_reg    <= in_data.chan_a;
            b1_reg    <= in_data.chan_b;
            c1_reg    <= in_data.chan_c;
            rgn1_reg  <= rgn_in;
            rem1_reg  <= rem_wide[7:0];
        end
        if (adv2 && v1_reg) begin
            kind2_reg  <= kind1_reg;
            zero2_reg  <= zero1_reg;
            a2_reg     <= a1_reg;
            b2_reg     <= b1_reg;
            c2_reg     <= c1_reg;
            rgn2_reg   <= rgn1_reg;
            pprod2_reg <= 16'(c1_reg) * 16'(FULL_SCALE - b1_reg);
            qs2_reg    <= 16'(b1_reg) * 16'(rem1_reg);
            ts2_reg    <= 16'(b1_reg) * 16'(FULL_SCALE - rem1_reg);
        end
        if (adv3 && v2_reg) begin
            word3_reg <= word_next;
        end
    end

    // In stage 2 the saturation sits in b2 and the value in c2.
    assign qprod = 16'(c2_reg) * 16'(FULL_SCALE - qs2_reg[15:8]);
    assign tprod = 16'(c2_reg) * 16'(FULL_SCALE - ts2_reg[15:8]);
    assign p_val = pprod2_reg[15:8];
    assign q_val = qprod[15:8];
    assign t_val = tprod[15:8];

    always_comb begin
        word_next = '0;
        if (!kind2_reg) begin
            word_next = '{green: b2_reg, red: a2_reg, blue: c2_reg};
        end else if (zero2_reg) begin
            word_next = '{green: c2_reg, red: c2_reg, blue: c2_reg};
        end else begin
            case (rgn2_reg)
                RGN_0:   word_next = '{green: t_val,  red: c2_reg, blue: p_val};
                RGN_1:   word_next = '{green: c2_reg, red: q_val,  blue: p_val};
                RGN_2:   word_next = '{green: c2_reg, red: p_val,  blue: t_val};
                RGN_3:   word_next = '{green: q_val,  red: p_val,  blue: c2_reg};
                RGN_4:   word_next = '{green: p_val,  red: t_val,  blue: c2_reg};
                default: word_next = '{green: p_val,  red: c2_reg, blue: q_val};
            endcase
        end
    end

    assign word_valid = v3_reg;
    assign word_data  = word3_reg;

endmodule

`default_nettype wire

// ===== design/hrle_queue.sv =====
// Short FIFO of colour words between the front and back ends.
// Depth is a parameter; depends on hrle_pkg for the word type.
`default_nettype none

module hrle_queue #(
    parameter int DEPTH = hrle_pkg::QUEUE_DEPTH
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             push_valid,
    output logic            push_ready,
    input  hrle_pkg::grb_t  push_data,
    output logic            pop_valid,
    input  wire             pop_ready,
    output hrle_pkg::grb_t  pop_data
);
    import hrle_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

    grb_t              mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;
    logic              push, pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/hrle_back.sv =====
// Back end: serializes the head colour word into 24 code beats and a gap beat.
// Holds the output register; depends on hrle_pkg.
`default_nettype none

module hrle_back (
    input  wire             aclk,
    input  wire             aresetn,
    input  hrle_pkg::cfg_t  cfg,
    input  wire             word_valid,
    output logic            word_ready,
    input  hrle_pkg::grb_t  word_data,
    output logic            out_valid,
    input  wire             out_ready,
    output hrle_pkg::out_t  out_data
);
    import hrle_pkg::*;

    logic             out_valid_reg, out_valid_next;
    out_t             out_data_reg, out_data_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             load;
    logic [CNT_W-1:0] bit_sel;
    logic             bit_val;
    logic [CFG_W-1:0] code;

    // The output register takes a new beat whenever it is empty or being drained.
    assign load    = !out_valid_reg || out_ready;
    assign bit_sel = TOP_BIT - cnt_reg;
    assign bit_val = word_data[bit_sel];
    assign code    = bit_val ? cfg.high_code : cfg.low_code;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        cnt_next       = cnt_reg;
        word_ready     = 1'b0;
        if (load) begin
            out_valid_next = word_valid;
            if (word_valid) begin
                if (cnt_reg == LAST_BEAT) begin
                    out_data_next = '{code_byte: '0, gap_len: cfg.gap_bytes, last: 1'b1};
                    cnt_next      = '0;
                    word_ready    = 1'b1;
                end else begin
                    out_data_next = '{code_byte: code[CFG_W-1:1], gap_len: '0, last: 1'b0};
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== design/hsv_to_rgb_led_bit_encoder.sv =====
// Top level of the colour to LED serial-code encoder.
// Instantiates hrle_front, hrle_queue and hrle_back; depends on hrle_pkg.
//
// Each input beat carries one colour, as RGB or as 8-bit HSV, and yields 25
// output beats: 24 code bytes (green, red, blue, each MSB first) and then one
// gap beat with last set and the configured gap length. The back end sends
// one beat per cycle while the output is ready and a colour is waiting, so the
// serializer sets the colour rate. The HSV conversion pipeline is registered
// and the queue lets the next colours be accepted while one is still being
// sent. Registers are written through cfg_we/cfg_index/cfg_wdata at any edge
// and should be changed only while the block is idle.
`default_nettype none

module hsv_to_rgb_led_bit_encoder #(
    parameter int QUEUE_DEPTH = hrle_pkg::QUEUE_DEPTH
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  hrle_pkg::in_t                      s_data,
    output logic                               m_valid,
    input  wire                                m_ready,
    output hrle_pkg::out_t                     m_data,
    input  wire                                cfg_we,
    input  wire  [hrle_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [hrle_pkg::CFG_W-1:0]         cfg_wdata
);
    import hrle_pkg::*;

    cfg_t cfg_reg;
    logic word_valid, word_ready, head_valid, head_ready;
    grb_t word_data, head_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{high_code: HIGH_CODE_RST, low_code: LOW_CODE_RST,
                         gap_bytes: GAP_BYTES_RST};
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_HIGH_CODE: cfg_reg.high_code <= cfg_wdata;
                CFG_LOW_CODE:  cfg_reg.low_code  <= cfg_wdata;
                CFG_GAP_BYTES: cfg_reg.gap_bytes <= cfg_wdata;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    hrle_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_data    (s_data),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word_data  (word_data)
    );

    hrle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (word_valid),
        .push_ready (word_ready),
        .push_data  (word_data),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_data   (head_data)
    );

    hrle_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .word_valid (head_valid),
        .word_ready (head_ready),
        .word_data  (head_data),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (m_data)
    );

endmodule

`default_nettype wire

// ===== design/hrle_checker.sv =====
// Port-level checks for the color to LED serial-code encoder.
// Bound to hsv_to_rgb_led_bit_encoder; depends on hrle_pkg.
`default_nettype none

module hrle_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             m_valid,
    input wire                             m_ready,
    input hrle_pkg::out_t                  m_data
);
    import hrle_pkg::*;

    // Position of the next output beat within its run of 25.
    logic [CNT_W-1:0] beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg <= '0;
        end else if (m_valid && m_ready) begin
            beat_reg <= (beat_reg == LAST_BEAT) ? '0 : beat_reg + 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output beat changed while stalled");

    a_last_place: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == (beat_reg == LAST_BEAT)))
        else $error("gap beat not at the end of a 25-beat run");

    a_gap_zero_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last |-> (m_data.code_byte == '0))
        else $error("gap beat carries a code byte");

    a_bit_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> (m_data.gap_len == '0))
        else $error("bit beat carries a gap length");

endmodule

bind hsv_to_rgb_led_bit_encoder hrle_checker u_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);

`default_nettype wire
